/* hdl/cec_bit_receiver_macros.svh */
// Assertion helpers for the receiver RTL.
`ifndef CEC_BIT_RECEIVER_MACROS_SVH
`define CEC_BIT_RECEIVER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CBR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CBR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cbr_pkg.sv */
// ----------------------------------------------------------------------------
// cbr_pkg
// Types and constants for the CEC bit receiver.
// ----------------------------------------------------------------------------
package cbr_pkg;

    localparam int CFG_W   = 13;
    localparam int CFG_N   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W   = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_LOW_MIN   = 3'd0,
        CFG_START_TOTAL_MIN = 3'd1,
        CFG_ZERO_LOW_MIN    = 3'd2,
        CFG_ZERO_LOW_MAX    = 3'd3,
        CFG_ONE_LOW_MIN     = 3'd4,
        CFG_ONE_LOW_MAX     = 3'd5,
        CFG_BIT_TOTAL_MIN   = 3'd6,
        CFG_BIT_TOTAL_MAX   = 3'd7
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] RST_START_LOW_MIN   = 13'd3680;
    localparam logic [CFG_W-1:0] RST_START_TOTAL_MIN = 13'd4521;
    localparam logic [CFG_W-1:0] RST_ZERO_LOW_MIN    = 13'd1366;
    localparam logic [CFG_W-1:0] RST_ZERO_LOW_MAX    = 13'd1787;
    localparam logic [CFG_W-1:0] RST_ONE_LOW_MIN     = 13'd420;
    localparam logic [CFG_W-1:0] RST_ONE_LOW_MAX     = 13'd1051;
    localparam logic [CFG_W-1:0] RST_BIT_TOTAL_MIN   = 13'd2155;
    localparam logic [CFG_W-1:0] RST_BIT_TOTAL_MAX   = 13'd2891;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_START_LOW  = 3'd1,
        PH_START_HIGH = 3'd2,
        PH_BIT_LOW    = 3'd3,
        PH_BIT_HIGH   = 3'd4
    } t_phase;

    typedef struct packed {
        logic [CFG_W-1:0] start_low_min;
        logic [CFG_W-1:0] start_total_min;
        logic [CFG_W-1:0] zero_low_min;
        logic [CFG_W-1:0] zero_low_max;
        logic [CFG_W-1:0] one_low_min;
        logic [CFG_W-1:0] one_low_max;
        logic [CFG_W-1:0] bit_total_min;
        logic [CFG_W-1:0] bit_total_max;
    } t_cfg;

    typedef struct packed {
        logic start_low_ok;
        logic start_total_ok;
        logic zero_ok;
        logic one_ok;
        logic total_ok;
    } t_judge;

    typedef struct packed {
        logic             bit_value;
        logic [POS_W-1:0] bit_position;
        logic             block_end;
    } t_result;

endpackage

/* hdl/cbr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// cbr_cfg_regs
// Timing threshold registers, written through a plain write port.
// ----------------------------------------------------------------------------
module cbr_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cbr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cbr_pkg::CFG_W-1:0]      i_cfg_data,
    output cbr_pkg::t_cfg                  o_cfg
);
    import cbr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_START_LOW_MIN:   n_cfg.start_low_min   = i_cfg_data;
                CFG_START_TOTAL_MIN: n_cfg.start_total_min = i_cfg_data;
                CFG_ZERO_LOW_MIN:    n_cfg.zero_low_min    = i_cfg_data;
                CFG_ZERO_LOW_MAX:    n_cfg.zero_low_max    = i_cfg_data;
                CFG_ONE_LOW_MIN:     n_cfg.one_low_min     = i_cfg_data;
                CFG_ONE_LOW_MAX:     n_cfg.one_low_max     = i_cfg_data;
                CFG_BIT_TOTAL_MIN:   n_cfg.bit_total_min   = i_cfg_data;
                CFG_BIT_TOTAL_MAX:   n_cfg.bit_total_max   = i_cfg_data;
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low_min   <= RST_START_LOW_MIN;
            r_cfg.start_total_min <= RST_START_TOTAL_MIN;
            r_cfg.zero_low_min    <= RST_ZERO_LOW_MIN;
            r_cfg.zero_low_max    <= RST_ZERO_LOW_MAX;
            r_cfg.one_low_min     <= RST_ONE_LOW_MIN;
            r_cfg.one_low_max     <= RST_ONE_LOW_MAX;
            r_cfg.bit_total_min   <= RST_BIT_TOTAL_MIN;
            r_cfg.bit_total_max   <= RST_BIT_TOTAL_MAX;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/cbr_timing.sv */
// ----------------------------------------------------------------------------
// cbr_timing
// Saturating elapsed-tick count and the threshold window compares.
// ----------------------------------------------------------------------------
module cbr_timing #(
    parameter int TIMER_WIDTH = 13
) (
    input  logic [TIMER_WIDTH-1:0] i_timer,
    input  cbr_pkg::t_cfg          i_cfg,
    output logic [TIMER_WIDTH-1:0] o_elapsed,
    output cbr_pkg::t_judge        o_judge
);
    import cbr_pkg::*;

    localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

    logic [TIMER_WIDTH-1:0] w_t;

    assign w_t       = (i_timer == TMAX) ? TMAX : i_timer + 1'b1;
    assign o_elapsed = w_t;

    always_comb begin
        o_judge.start_low_ok   = w_t >= TIMER_WIDTH'(i_cfg.start_low_min);
        o_judge.start_total_ok = w_t >= TIMER_WIDTH'(i_cfg.start_total_min);
        o_judge.zero_ok        = (w_t > TIMER_WIDTH'(i_cfg.zero_low_min)) &&
                                 (w_t < TIMER_WIDTH'(i_cfg.zero_low_max));
        o_judge.one_ok         = (w_t > TIMER_WIDTH'(i_cfg.one_low_min)) &&
                                 (w_t < TIMER_WIDTH'(i_cfg.one_low_max));
        o_judge.total_ok       = (w_t > TIMER_WIDTH'(i_cfg.bit_total_min)) &&
                                 (w_t < TIMER_WIDTH'(i_cfg.bit_total_max));
    end

endmodule

/* hdl/cbr_decoder.sv */
// ----------------------------------------------------------------------------
// cbr_decoder
// Start/data bit decode state machine with tick timer and bit index.
// ----------------------------------------------------------------------------
module cbr_decoder #(
    parameter int BLOCK_BITS  = 10,
    parameter int TIMER_WIDTH = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_level,
    input  cbr_pkg::t_cfg    i_cfg,
    output logic             o_emit,
    output cbr_pkg::t_result o_result
);
    import cbr_pkg::*;

    localparam logic [POS_W-1:0] LAST_IDX = POS_W'(BLOCK_BITS - 1);

    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [TIMER_WIDTH-1:0] r_timer;
    logic [TIMER_WIDTH-1:0] n_timer;
    logic                   r_prev;
    logic                   r_pend;
    logic                   n_pend;
    logic [POS_W-1:0]       r_idx;
    logic [POS_W-1:0]       n_idx;

    logic [TIMER_WIDTH-1:0] w_elapsed;
    t_judge                 w_judge;
    logic                   w_fall;
    logic                   w_rise;
    logic                   w_last;
    logic                   w_restart;

    cbr_timing #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_timing (
        .i_timer   (r_timer),
        .i_cfg     (i_cfg),
        .o_elapsed (w_elapsed),
        .o_judge   (w_judge)
    );

    assign w_fall = r_prev & ~i_level;
    assign w_rise = ~r_prev & i_level;
    assign w_last = r_idx >= LAST_IDX;

    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_pend    = r_pend;
        w_restart = 1'b0;
        o_emit    = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (w_fall) begin
                    w_restart = 1'b1;
                    n_idx     = '0;
                    n_phase   = PH_START_LOW;
                end
            end
            PH_START_LOW: begin
                if (w_rise) begin
                    n_phase = w_judge.start_low_ok ? PH_START_HIGH : PH_IDLE;
                end
            end
            PH_START_HIGH: begin
                if (w_fall) begin
                    if (w_judge.start_total_ok) begin
                        w_restart = 1'b1;
                        n_phase   = PH_BIT_LOW;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_BIT_LOW: begin
                if (w_rise) begin
                    if (w_judge.zero_ok) begin
                        n_pend  = 1'b0;
                        n_phase = PH_BIT_HIGH;
                    end else if (w_judge.one_ok) begin
                        n_pend  = 1'b1;
                        n_phase = PH_BIT_HIGH;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_BIT_HIGH: begin
                if (w_fall) begin
                    if (w_judge.total_ok) begin
                        o_emit    = 1'b1;
                        w_restart = 1'b1;
                        n_idx     = w_last ? '0 : r_idx + 1'b1;
                        n_phase   = PH_BIT_LOW;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: n_phase = PH_IDLE;
        endcase
        n_timer = w_restart ? '0 : w_elapsed;
    end

    assign o_result.bit_value    = r_pend;
    assign o_result.bit_position = r_idx;
    assign o_result.block_end    = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_timer <= '0;
            r_prev  <= 1'b1;
            r_pend  <= 1'b0;
            r_idx   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_prev  <= i_level;
            r_pend  <= n_pend;
            r_idx   <= n_idx;
        end
    end

endmodule

/* hdl/cec_bit_receiver.sv */
// Path: a line sample beat is registered on acceptance; the bit it completes
// is then loaded into the result register when the decoder steps on that beat.
// Throughput: one sample beat per cycle; only a result register still held by
// the sink stalls a sample that completes a bit.
// Reset: synchronous active low; thresholds return to their defaults, the
// decoder to idle with the line taken as high.
// ----------------------------------------------------------------------------
// cec_bit_receiver
// CEC line bit receiver: start-bit detection and timed data-bit decode.
// ----------------------------------------------------------------------------
`include "cec_bit_receiver_macros.svh"

module cec_bit_receiver #(
    parameter int BLOCK_BITS  = 10,
    parameter int TIMER_WIDTH = 13
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cbr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cbr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_line_level,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_bit_value,
    output logic [cbr_pkg::POS_W-1:0]     o_bit_position,
    output logic                          o_block_end
);
    import cbr_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_BITS - 1);

    t_cfg    w_cfg;
    logic    r_in_vld;
    logic    r_in_level;
    logic    r_out_vld;
    t_result r_out;
    logic    w_emit;
    t_result w_result;
    logic    w_out_free;
    logic    w_step;

    cbr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    cbr_decoder #(
        .BLOCK_BITS  (BLOCK_BITS),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_level  (r_in_level),
        .i_cfg    (w_cfg),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_step     = r_in_vld && (!w_emit || w_out_free);
    assign o_in_ready = !r_in_vld || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_level <= i_line_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_step && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_bit_value    = r_out.bit_value;
    assign o_bit_position = r_out.bit_position;
    assign o_block_end    = r_out.block_end;

    `CBR_ASSERT_IMP(a_emit_into_free, w_step && w_emit, w_out_free, "result beat overwritten")
    `CBR_ASSERT_IMP(a_end_matches_pos, r_out_vld, r_out.block_end == (r_out.bit_position == LAST_POS), "block end mismatch")
    `CBR_ASSERT_IMP(a_pos_in_block, r_out_vld, r_out.bit_position <= LAST_POS, "bit position past block")
    `CBR_ASSERT_NXT(a_stall_keeps_beat, r_in_vld && !w_step, r_in_vld && $stable(r_in_level), "stalled sample lost")

endmodule

/* sim/tb_cec_bit_receiver.sv */
// ----------------------------------------------------------------------------
// tb_cec_bit_receiver
// Self-checking bench for the CEC bit receiver. Line samples are streamed one
// beat at a time. A cycle-free decoder model follows every accepted beat and
// queues the bits it expects. Each result beat is checked against that queue.
// Tests cover default timing, block wrap, start-bit rules, saturating and
// zeroed thresholds, and random well-formed and broken frames, with random
// source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_cec_bit_receiver;
    import cbr_pkg::*;

    localparam int          BLOCK_LEN     = 10;
    localparam int          TICK_W        = 13;
    localparam int unsigned TICK_MAX      = (1 << TICK_W) - 1;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          DRAIN_LIMIT   = 4000;

    localparam t_cfg DEFAULT_THRESHOLDS = '{
        RST_START_LOW_MIN, RST_START_TOTAL_MIN, RST_ZERO_LOW_MIN, RST_ZERO_LOW_MAX,
        RST_ONE_LOW_MIN, RST_ONE_LOW_MAX, RST_BIT_TOTAL_MIN, RST_BIT_TOTAL_MAX
    };
    // one: low 1, zero: low 2, bit total 3 or 4
    localparam t_cfg TIGHT_THRESHOLDS = '{
        13'd1, 13'd2, 13'd1, 13'd3, 13'd0, 13'd2, 13'd2, 13'd5
    };
    // windows wide open, start needs a saturated timer
    localparam t_cfg WIDE_THRESHOLDS = '{
        13'h1FFF, 13'h1FFF, 13'd0, 13'h1FFF, 13'd0, 13'h1FFF, 13'd0, 13'h1FFF
    };

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data     = '0;
    logic             i_in_valid     = 1'b0;
    logic             i_line_level   = 1'b1;
    logic             i_out_ready    = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic             o_bit_value;
    logic [POS_W-1:0] o_bit_position;
    logic             o_block_end;

    // decoder model state
    t_cfg             thresholds = DEFAULT_THRESHOLDS;
    t_phase           dec_phase  = PH_IDLE;
    int unsigned      dec_timer  = 0;
    logic             dec_prev   = 1'b1;
    logic             dec_class  = 1'b0;
    logic [POS_W-1:0] dec_index  = '0;

    t_result          awaited_bits[$];

    int errors         = 0;
    int samples_sent   = 0;
    int bits_predicted = 0;
    int bits_checked   = 0;
    int block_ends     = 0;
    int stall_left     = 0;
    bit src_gaps       = 1'b1;
    bit sink_stalls    = 1'b1;

    cec_bit_receiver #(
        .BLOCK_BITS  (BLOCK_LEN),
        .TIMER_WIDTH (TICK_W)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_line_level   (i_line_level),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_bit_value    (o_bit_value),
        .o_bit_position (o_bit_position),
        .o_block_end    (o_block_end)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL cec_bit_receiver");
        $finish;
    end

    // Advance the model by one line sample; queue the bit it completes.
    function automatic void decode_sample(input logic lvl);
        logic        fall;
        logic        rise;
        logic        restart;
        int unsigned t;
        t_result     r;
        fall     = dec_prev & ~lvl;
        rise     = ~dec_prev & lvl;
        restart  = 1'b0;
        t        = (dec_timer < TICK_MAX) ? dec_timer + 1 : dec_timer;
        dec_prev = lvl;
        case (dec_phase)
            PH_IDLE: begin
                if (fall) begin
                    restart   = 1'b1;
                    dec_index = '0;
                    dec_phase = PH_START_LOW;
                end
            end
            PH_START_LOW: begin
                if (rise) begin
                    if (t >= thresholds.start_low_min) dec_phase = PH_START_HIGH;
                    else dec_phase = PH_IDLE;
                end
            end
            PH_START_HIGH: begin
                if (fall) begin
                    if (t >= thresholds.start_total_min) begin
                        restart   = 1'b1;
                        dec_phase = PH_BIT_LOW;
                    end else begin
                        dec_phase = PH_IDLE;
                    end
                end
            end
            PH_BIT_LOW: begin
                if (rise) begin
                    if (t > thresholds.zero_low_min && t < thresholds.zero_low_max) begin
                        dec_class = 1'b0;
                        dec_phase = PH_BIT_HIGH;
                    end else if (t > thresholds.one_low_min && t < thresholds.one_low_max) begin
                        dec_class = 1'b1;
                        dec_phase = PH_BIT_HIGH;
                    end else begin
                        dec_phase = PH_IDLE;
                    end
                end
            end
            PH_BIT_HIGH: begin
                if (fall) begin
                    if (t > thresholds.bit_total_min && t < thresholds.bit_total_max) begin
                        r.bit_value    = dec_class;
                        r.bit_position = dec_index;
                        r.block_end    = (dec_index >= BLOCK_LEN - 1);
                        awaited_bits.push_back(r);
                        bits_predicted++;
                        dec_index = r.block_end ? '0 : dec_index + 1'b1;
                        restart   = 1'b1;
                        dec_phase = PH_BIT_LOW;
                    end else begin
                        dec_phase = PH_IDLE;
                    end
                end
            end
            default: dec_phase = PH_IDLE;
        endcase
        dec_timer = restart ? 0 : t;
    endfunction

    always @(posedge i_clk) begin : bit_checker
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_bits.size() == 0) begin
                $error("unexpected bit beat: value %0b position %0d end %0b",
                       o_bit_value, o_bit_position, o_block_end);
                errors++;
            end else begin
                want = awaited_bits.pop_front();
                if (o_bit_value !== want.bit_value) begin
                    $error("bit_value: expected %0b, got %0b", want.bit_value, o_bit_value);
                    errors++;
                end
                if (o_bit_position !== want.bit_position) begin
                    $error("bit_position: expected %0d, got %0d",
                           want.bit_position, o_bit_position);
                    errors++;
                end
                if (o_block_end !== want.block_end) begin
                    $error("block_end: expected %0b, got %0b", want.block_end, o_block_end);
                    errors++;
                end
                bits_checked++;
                if (want.block_end) block_ends++;
            end
        end
    end

    always @(posedge i_clk) begin : sink_pacing
        int roll;
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else if (!sink_stalls) begin
            i_out_ready <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                i_out_ready <= 1'b1;
            end else if (roll < 96) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(10, 60);
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        if (!src_gaps) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Value strictly inside an open interval.
    function automatic int pick_inside(input int lo_x, input int hi_x);
        if (hi_x >= lo_x + 2) return $urandom_range(lo_x + 1, hi_x - 1);
        return lo_x + 1;
    endfunction

    function automatic t_cfg random_thresholds();
        t_cfg c;
        c.one_low_min     = CFG_W'($urandom_range(0, 3));
        c.one_low_max     = CFG_W'(c.one_low_min + $urandom_range(2, 5));
        // sometimes let the zero window overlap the one window
        if ($urandom_range(0, 4) == 0) c.zero_low_min = c.one_low_min;
        else c.zero_low_min = CFG_W'(c.one_low_max + $urandom_range(0, 2));
        c.zero_low_max    = CFG_W'(c.zero_low_min + $urandom_range(2, 5));
        c.bit_total_min   = CFG_W'(c.zero_low_max + $urandom_range(0, 4));
        c.bit_total_max   = CFG_W'(c.bit_total_min + $urandom_range(2, 8));
        c.start_low_min   = CFG_W'($urandom_range(0, 12));
        c.start_total_min = CFG_W'(c.start_low_min + $urandom_range(0, 10));
        return c;
    endfunction

    task automatic send_sample(input logic lvl);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_line_level <= lvl;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        decode_sample(lvl);
        samples_sent++;
    endtask

    task automatic send_run(input logic lvl, input int n);
        repeat (n) send_sample(lvl);
    endtask

    task automatic send_pulse(input int lo, input int hi);
        send_run(1'b0, lo);
        send_run(1'b1, hi);
    endtask

    // Stop the source and wait until every predicted bit beat has been taken.
    task automatic flush_bits();
        int waited;
        i_in_valid <= 1'b0;
        waited = 0;
        while (awaited_bits.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (awaited_bits.size() != 0) begin
            $error("%0d decoded bits never arrived", awaited_bits.size());
            errors++;
            awaited_bits.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_START_LOW_MIN:   thresholds.start_low_min   = val;
            CFG_START_TOTAL_MIN: thresholds.start_total_min = val;
            CFG_ZERO_LOW_MIN:    thresholds.zero_low_min    = val;
            CFG_ZERO_LOW_MAX:    thresholds.zero_low_max    = val;
            CFG_ONE_LOW_MIN:     thresholds.one_low_min     = val;
            CFG_ONE_LOW_MAX:     thresholds.one_low_max     = val;
            CFG_BIT_TOTAL_MIN:   thresholds.bit_total_min   = val;
            CFG_BIT_TOTAL_MAX:   thresholds.bit_total_max   = val;
            default: ;
        endcase
    endtask

    task automatic load_thresholds(input t_cfg c);
        write_reg(CFG_START_LOW_MIN,   c.start_low_min);
        write_reg(CFG_START_TOTAL_MIN, c.start_total_min);
        write_reg(CFG_ZERO_LOW_MIN,    c.zero_low_min);
        write_reg(CFG_ZERO_LOW_MAX,    c.zero_low_max);
        write_reg(CFG_ONE_LOW_MIN,     c.one_low_min);
        write_reg(CFG_ONE_LOW_MAX,     c.one_low_max);
        write_reg(CFG_BIT_TOTAL_MIN,   c.bit_total_min);
        write_reg(CFG_BIT_TOTAL_MAX,   c.bit_total_max);
        i_cfg_we <= 1'b0;
    endtask

    // Start bit, nbits data bits shaped for the current thresholds, then a long
    // low that ends the frame. break_pct percent of the timings are scrambled.
    task automatic send_frame(input int nbits, input int break_pct);
        int lo;
        int hi;
        int span;
        span = int'(thresholds.bit_total_max) + 3;
        lo = int'(thresholds.start_low_min) + int'($urandom_range(0, 3));
        if (lo < 1) lo = 1;
        hi = int'(thresholds.start_total_min) + int'($urandom_range(0, 3)) - lo;
        if (hi < 1) hi = 1;
        if (int'($urandom_range(0, 99)) < break_pct) lo = $urandom_range(1, lo + 2);
        send_pulse(lo, hi);
        repeat (nbits) begin
            if ($urandom_range(0, 1))
                lo = pick_inside(thresholds.one_low_min, thresholds.one_low_max);
            else
                lo = pick_inside(thresholds.zero_low_min, thresholds.zero_low_max);
            hi = pick_inside(thresholds.bit_total_min, thresholds.bit_total_max) - lo;
            if (hi < 1) hi = 1;
            if (int'($urandom_range(0, 99)) < break_pct) lo = $urandom_range(1, span);
            if (int'($urandom_range(0, 99)) < break_pct) hi = $urandom_range(1, span);
            send_pulse(lo, hi);
        end
        lo = (thresholds.zero_low_max > thresholds.one_low_max) ?
             int'(thresholds.zero_low_max) : int'(thresholds.one_low_max);
        send_pulse(lo + int'($urandom_range(0, 3)), $urandom_range(1, 6));
    endtask

    task automatic test_default_timing();
        flush_bits();
        load_thresholds(DEFAULT_THRESHOLDS);
        send_run(1'b1, 5);
        send_frame(3, 0);
    endtask

    task automatic test_block_wrap();
        flush_bits();
        load_thresholds(TIGHT_THRESHOLDS);
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        send_run(1'b1, 3);
        send_pulse(2, 1);
        for (int k = 0; k < 12; k++) begin
            if (k % 3 == 1) send_pulse(2, 2);
            else send_pulse(1, 2);
        end
        send_pulse(3, 2);
        // aborted mid-block, next frame restarts at position 0
        send_pulse(2, 1);
        repeat (3) send_pulse(1, 2);
        send_pulse(3, 2);
        send_pulse(2, 1);
        send_pulse(2, 2);
        send_pulse(1, 2);
        send_pulse(3, 2);
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    task automatic test_start_rules();
        t_cfg c;
        c = TIGHT_THRESHOLDS;
        c.start_low_min   = 13'd3;
        c.start_total_min = 13'd6;
        flush_bits();
        load_thresholds(c);
        send_pulse(1, 2);  // low too short
        send_pulse(3, 1);  // total too short; its closing edge must not restart
        send_pulse(3, 3);
        send_pulse(3, 3);
        send_pulse(1, 2);
        send_pulse(3, 2);
    endtask

    task automatic test_threshold_extremes();
        flush_bits();
        load_thresholds(WIDE_THRESHOLDS);
        send_pulse(8200, 2);
        send_pulse(2, 2);
        send_pulse(5, 1);
        send_pulse(1, 3);
        send_run(1'b0, 1);
        flush_bits();
        load_thresholds('0);
        send_run(1'b1, 1);
        send_pulse(1, 1);
        send_pulse(1, 1);
        send_run(1'b1, 2);
    endtask

    task automatic test_random_traffic();
        int base_samples;
        int phase_start;
        int phase;
        base_samples = samples_sent;
        phase        = 0;
        while (samples_sent - base_samples < 800) begin
            flush_bits();
            load_thresholds(random_thresholds());
            src_gaps    = (phase % 3) != 0;
            sink_stalls = (phase % 4) != 1;
            phase_start = samples_sent;
            while (samples_sent - phase_start < 80) begin
                if ($urandom_range(0, 5) == 0) begin
                    repeat ($urandom_range(2, 8))
                        send_run(1'($urandom_range(0, 1)), $urandom_range(1, 10));
                end else begin
                    send_frame($urandom_range(1, 14), 8);
                end
            end
            phase++;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_timing();
        test_block_wrap();
        test_start_rules();
        test_threshold_extremes();
        test_random_traffic();
        flush_bits();
        $display("line samples sent: %0d over default, tight, saturating and random timing",
                 samples_sent);
        $display("decoded bits compared: %0d, block ends among them: %0d",
                 bits_checked, block_ends);
        if (errors == 0) begin
            $display("PASS cec_bit_receiver");
        end else begin
            $display("FAIL cec_bit_receiver");
        end
        $finish;
    end

endmodule
